### hw/rtl/nnts_pkg.sv
// Shared types and constants of the nearest-neighbor thumbnail scaler.
package nnts_pkg;

   localparam int COLOR_W     = 8;
   localparam int POS_W       = 12;
   localparam int SIZE_W      = 13;
   localparam int CFG_W       = 13;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 80;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] SOURCE_DIM_RESET = 13'd256;

   typedef enum logic [2:0] {
      ST_LATCH,
      ST_SHORT_GO,
      ST_SHORT_WAIT,
      ST_W_GO,
      ST_W_WAIT,
      ST_H_GO,
      ST_H_WAIT,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic start_short;
      logic take_short;
      logic start_w;
      logic take_w;
      logic start_h;
      logic take_h;
      logic accept;
   } dp_cmd_type;

   typedef struct packed {
      logic frame_start;
      logic scale_needed;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

### hw/rtl/nearest_neighbor_thumbnail_scaler.sv
// Top level of the nearest-neighbor thumbnail scaler.
//
// Source pixels enter on req_* in raster order, one RGBA pixel per
// transaction; alpha is dropped. Thumbnail pixels leave on rsp_* with their
// thumbnail column, row and the frame's thumbnail size; rsp_tlast marks the
// final thumbnail pixel of a frame. Source pixels not sampled give no output.
// csr_* writes source_width (index 0) and source_height (index 1); a write
// takes effect at the next frame start.
// Setup: after reset, and at a frame start following a register write, the
// block runs up to three divisions on one shared iterative divider before it
// takes the first pixel: three for a frame that is scaled, two for one that
// is not. Within a frame one pixel is accepted per cycle while the output
// register is free; a result appears on rsp_* the cycle after its pixel is
// accepted, from a single output register. If the receiver stalls with a
// result held, req_tready drops until it is taken. Reset is synchronous and
// returns the raster position to frame start and the registers to 256 x 256.
module nearest_neighbor_thumbnail_scaler #(
   parameter int THUMB_SIZE = 128,
   parameter int MAX_DIM    = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
   input  logic [nnts_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16], thumb_col[35:24],
   // thumb_row[47:36], thumb_width[60:48], thumb_height[73:61], zero pad
   output logic [nnts_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nnts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nnts_pkg::CFG_W-1:0]         csr_data
);

   nnts_pkg::dp_cmd_type    cmd;
   nnts_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   nnts_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .status     (status),
      .cmd        (cmd)
   );

   nnts_datapath #(
      .THUMB_SIZE (THUMB_SIZE),
      .MAX_DIM    (MAX_DIM)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

### hw/rtl/nnts_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module nnts_divider #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit drops safely
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### hw/rtl/nnts_controller.sv
// Sequencer: frame setup divisions, then pixel acceptance.
module nnts_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   csr_valid,
   input  nnts_pkg::dp_status_type status,
   output nnts_pkg::dp_cmd_type    cmd
);

   nnts_pkg::ctrl_state_type state_ff, state_in;
   logic stale_ff, stale_in;
   logic ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nnts_pkg::ST_LATCH;
         stale_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stale_ff <= stale_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ready    = 1'b0;
      // a write mid-frame is held back until the next frame start
      stale_in = stale_ff | csr_valid;
      case (state_ff)
         nnts_pkg::ST_LATCH: begin
            cmd.latch = 1'b1;
            stale_in  = csr_valid;
            state_in  = nnts_pkg::ST_SHORT_GO;
         end
         nnts_pkg::ST_SHORT_GO: begin
            if (status.scale_needed) begin
               cmd.start_short = 1'b1;
               state_in        = nnts_pkg::ST_SHORT_WAIT;
            end else begin
               state_in = nnts_pkg::ST_W_GO;
            end
         end
         nnts_pkg::ST_SHORT_WAIT: begin
            if (status.div_done) begin
               cmd.take_short = 1'b1;
               state_in       = nnts_pkg::ST_W_GO;
            end
         end
         nnts_pkg::ST_W_GO: begin
            cmd.start_w = 1'b1;
            state_in    = nnts_pkg::ST_W_WAIT;
         end
         nnts_pkg::ST_W_WAIT: begin
            if (status.div_done) begin
               cmd.take_w = 1'b1;
               state_in   = nnts_pkg::ST_H_GO;
            end
         end
         nnts_pkg::ST_H_GO: begin
            cmd.start_h = 1'b1;
            state_in    = nnts_pkg::ST_H_WAIT;
         end
         nnts_pkg::ST_H_WAIT: begin
            if (status.div_done) begin
               cmd.take_h = 1'b1;
               state_in   = nnts_pkg::ST_RUN;
            end
         end
         nnts_pkg::ST_RUN: begin
            if (status.frame_start && stale_ff) begin
               state_in = nnts_pkg::ST_LATCH;
            end else begin
               ready      = status.out_free;
               cmd.accept = req_tvalid && status.out_free;
            end
         end
         default: begin
            state_in = nnts_pkg::ST_LATCH;
         end
      endcase
   end

   assign req_tready = ready;

endmodule

### hw/rtl/nnts_datapath.sv
// Datapath: config registers, frame setup, pick accumulators, output register.
module nnts_datapath #(
   parameter int THUMB_SIZE = 128,
   parameter int MAX_DIM    = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [nnts_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_valid,
   input  logic [nnts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nnts_pkg::CFG_W-1:0]           csr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [nnts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  nnts_pkg::dp_cmd_type                 cmd,
   output nnts_pkg::dp_status_type              status
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int CW = $clog2(MAX_DIM);
   localparam int PW = DW + $clog2(THUMB_SIZE + 1);
   localparam int CLR = nnts_pkg::COLOR_W;

   function automatic logic [DW-1:0] clamp_dim(input logic [nnts_pkg::CFG_W-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) r = DW'(1);
      else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
      else r = DW'(v);
      return r;
   endfunction

   // configuration
   logic [nnts_pkg::CFG_W-1:0] cfg_w_ff, cfg_w_in, cfg_h_ff, cfg_h_in;

   // frame setup
   logic [DW-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [DW-1:0] dw_ff, dw_in, dh_ff, dh_in;
   logic [DW-1:0] qw_ff, qw_in, rw_ff, rw_in, qh_ff, qh_in, rh_ff, rh_in;

   // raster and pick state
   logic [CW-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [DW-1:0] dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [DW-1:0] pick_col_ff, pick_col_in, col_rem_ff, col_rem_in;
   logic [DW-1:0] pick_row_ff, pick_row_in, row_rem_ff, row_rem_in;

   // output register
   logic                         out_valid_ff, out_valid_in;
   logic [nnts_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                         out_last_ff, out_last_in;

   // divider
   logic          div_start, div_done;
   logic [PW-1:0] div_num, div_quo;
   logic [DW-1:0] div_den, div_rem;

   logic          wide;
   logic [DW-1:0] long_side, short_side, short_dim;
   logic          row_hit, col_hit, col_wrap, row_wrap;
   logic [DW:0]   col_sum, row_sum;
   logic [DW:0]   src_col_next, src_row_next;

   assign wide       = fw_ff >= fh_ff;
   assign long_side  = wide ? fw_ff : fh_ff;
   assign short_side = wide ? fh_ff : fw_ff;
   assign short_dim  = (div_quo == '0) ? DW'(1) : DW'(div_quo);

   always_comb begin
      div_start = cmd.start_short | cmd.start_w | cmd.start_h;
      if (cmd.start_short) begin
         div_num = PW'(short_side) * PW'(THUMB_SIZE);
         div_den = long_side;
      end else if (cmd.start_w) begin
         div_num = PW'(fw_ff);
         div_den = dw_ff;
      end else begin
         div_num = PW'(fh_ff);
         div_den = dh_ff;
      end
   end

   nnts_divider #(
      .NUM_W (PW),
      .DEN_W (DW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      row_hit      = (dst_row_ff < dh_ff) && ({1'b0, src_row_ff} == (CW+1)'(pick_row_ff));
      col_hit      = row_hit && (dst_col_ff < dw_ff) &&
                     ({1'b0, src_col_ff} == (CW+1)'(pick_col_ff));
      col_sum      = {1'b0, col_rem_ff} + {1'b0, rw_ff};
      row_sum      = {1'b0, row_rem_ff} + {1'b0, rh_ff};
      src_col_next = (DW+1)'(src_col_ff) + 1'b1;
      src_row_next = (DW+1)'(src_row_ff) + 1'b1;
      col_wrap     = src_col_next >= {1'b0, fw_ff};
      row_wrap     = src_row_next >= {1'b0, fh_ff};

      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      if (csr_valid) begin
         if (csr_index == nnts_pkg::REG_SOURCE_WIDTH) cfg_w_in = csr_data;
         if (csr_index == nnts_pkg::REG_SOURCE_HEIGHT) cfg_h_in = csr_data;
      end

      fw_in = fw_ff;  fh_in = fh_ff;  dw_in = dw_ff;  dh_in = dh_ff;
      qw_in = qw_ff;  rw_in = rw_ff;  qh_in = qh_ff;  rh_in = rh_ff;
      if (cmd.latch) begin
         fw_in = clamp_dim(cfg_w_ff);
         fh_in = clamp_dim(cfg_h_ff);
         dw_in = clamp_dim(cfg_w_ff);
         dh_in = clamp_dim(cfg_h_ff);
      end
      if (cmd.take_short) begin
         if (wide) begin
            dw_in = DW'(THUMB_SIZE);
            dh_in = short_dim;
         end else begin
            dh_in = DW'(THUMB_SIZE);
            dw_in = short_dim;
         end
      end
      if (cmd.take_w) begin
         qw_in = DW'(div_quo);
         rw_in = div_rem;
      end
      if (cmd.take_h) begin
         qh_in = DW'(div_quo);
         rh_in = div_rem;
      end

      src_col_in  = src_col_ff;   src_row_in  = src_row_ff;
      dst_col_in  = dst_col_ff;   dst_row_in  = dst_row_ff;
      pick_col_in = pick_col_ff;  col_rem_in  = col_rem_ff;
      pick_row_in = pick_row_ff;  row_rem_in  = row_rem_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;

      if (cmd.accept) begin
         if (col_hit) begin
            out_valid_in = 1'b1;
            out_data_in  = nnts_pkg::RSP_DATA_W'({
               nnts_pkg::SIZE_W'(dh_ff),
               nnts_pkg::SIZE_W'(dw_ff),
               nnts_pkg::POS_W'(dst_row_ff),
               nnts_pkg::POS_W'(dst_col_ff),
               req_tdata[3*CLR-1:2*CLR],
               req_tdata[2*CLR-1:CLR],
               req_tdata[CLR-1:0]});
            out_last_in  = ((DW+1)'(dst_col_ff) + 1'b1 == {1'b0, dw_ff}) &&
                           ((DW+1)'(dst_row_ff) + 1'b1 == {1'b0, dh_ff});
            dst_col_in   = dst_col_ff + 1'b1;
            if (col_sum >= {1'b0, dw_ff}) begin
               col_rem_in  = DW'(col_sum - {1'b0, dw_ff});
               pick_col_in = pick_col_ff + qw_ff + 1'b1;
            end else begin
               col_rem_in  = col_sum[DW-1:0];
               pick_col_in = pick_col_ff + qw_ff;
            end
         end
         src_col_in = src_col_ff + 1'b1;
         if (col_wrap) begin
            src_col_in  = '0;
            dst_col_in  = '0;
            pick_col_in = '0;
            col_rem_in  = '0;
            if (row_hit) begin
               dst_row_in = dst_row_ff + 1'b1;
               if (row_sum >= {1'b0, dh_ff}) begin
                  row_rem_in  = DW'(row_sum - {1'b0, dh_ff});
                  pick_row_in = pick_row_ff + qh_ff + 1'b1;
               end else begin
                  row_rem_in  = row_sum[DW-1:0];
                  pick_row_in = pick_row_ff + qh_ff;
               end
            end
            src_row_in = src_row_ff + 1'b1;
            if (row_wrap) begin
               // end of frame: row state starts over for the next one
               src_row_in  = '0;
               dst_row_in  = '0;
               pick_row_in = '0;
               row_rem_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff     <= nnts_pkg::SOURCE_DIM_RESET;
         cfg_h_ff     <= nnts_pkg::SOURCE_DIM_RESET;
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         dst_col_ff   <= '0;
         dst_row_ff   <= '0;
         pick_col_ff  <= '0;
         col_rem_ff   <= '0;
         pick_row_ff  <= '0;
         row_rem_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_w_ff     <= cfg_w_in;
         cfg_h_ff     <= cfg_h_in;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         dst_col_ff   <= dst_col_in;
         dst_row_ff   <= dst_row_in;
         pick_col_ff  <= pick_col_in;
         col_rem_ff   <= col_rem_in;
         pick_row_ff  <= pick_row_in;
         row_rem_ff   <= row_rem_in;
         out_valid_ff <= out_valid_in;
      end
      fw_ff       <= fw_in;
      fh_ff       <= fh_in;
      dw_ff       <= dw_in;
      dh_ff       <= dh_in;
      qw_ff       <= qw_in;
      rw_ff       <= rw_in;
      qh_ff       <= qh_in;
      rh_ff       <= rh_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign status.frame_start  = (src_col_ff == '0) && (src_row_ff == '0);
   assign status.scale_needed = (fw_ff > THUMB_SIZE) || (fh_ff > THUMB_SIZE);
   assign status.div_done     = div_done;
   assign status.out_free     = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
